### hw/rtl/mss_pkg.sv
// Package: constants, node and state types, and merge function for the max-subarray tree.
`default_nettype none
package mss_pkg;
    localparam int MAX_ENTRIES = 1024;
    localparam int LEAF_W      = $clog2(MAX_ENTRIES);
    localparam int NODE_W      = LEAF_W + 1;
    localparam int SIZE_W      = 11;
    localparam int SUM_W       = 48;
    localparam int VAL_W       = 32;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] pre;
        logic [SUM_W-1:0] suf;
        logic [SUM_W-1:0] tot;
        logic [SUM_W-1:0] best;
    } t_node;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_READ,
        ST_UPD_MERGE,
        ST_QRY_NEXT,
        ST_QRY_READ,
        ST_QRY_DONE
    } t_state;

    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    function automatic logic signed [SUM_W-1:0] smax(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // Merge left and right nodes; an empty node is the identity.
    function automatic t_node merge(input t_node a, input t_node b);
        t_node r;
        if (!a.valid) return b;
        if (!b.valid) return a;
        r.valid = 1'b1;
        r.pre   = smax(a.pre, a.tot + b.pre);
        r.suf   = smax(b.suf, b.tot + a.suf);
        r.tot   = a.tot + b.tot;
        r.best  = smax(smax(a.best, b.best), a.suf + b.pre);
        return r;
    endfunction
endpackage
`default_nettype wire

### hw/rtl/max_subarray_segment_tree_top.sv
// Top level: segment tree in memory, update walks leaf to root, query walks two cursors up from the leaves.
// Update: busy from acceptance through LEAF_W merges and LEAF_W-1 sibling reads
//   (ST_UPD_MERGE and ST_UPD_READ alternate); the next transaction is taken once busy
//   drops, and an ignored update keeps busy low. Empty or inverted query: result strobed the next cycle, busy low.
// Query walk: per tree level up to two node reads (ST_QRY_NEXT, then ST_QRY_READ) and one
//   climb step; the result is strobed as busy drops.
// One transaction at a time; the receiver cannot stall. Synchronous active-low reset
//   sets r_size to 1024, then a clearing pass over all 2*MAX_ENTRIES nodes runs busy.
`default_nettype none
module max_subarray_segment_tree_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_cfg_we,
    input  wire logic [mss_pkg::SIZE_W-1:0] i_cfg_data,
    input  wire logic                       i_func,
    input  wire logic [mss_pkg::LEAF_W-1:0] i_position,
    input  wire logic signed [mss_pkg::VAL_W-1:0] i_new_value,
    input  wire logic [mss_pkg::LEAF_W-1:0] i_range_low,
    input  wire logic [mss_pkg::LEAF_W-1:0] i_range_high,
    output logic                            o_strobe,
    output logic signed [mss_pkg::SUM_W-1:0] o_best_sum,
    output logic                            o_status
);
    import mss_pkg::*;

    localparam int MEM_D = 2 * MAX_ENTRIES;
    localparam int CUR_W = NODE_W + 1;

    // Heap layout: node 1 is root, leaves at MAX_ENTRIES + index.
    t_node              r_mem [MEM_D];
    t_node              r_rdata;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size;
    logic [NODE_W-1:0]  r_clr, n_clr;     // clearing pass address
    logic [CUR_W-1:0]   r_node, n_node;   // update: current node; query: left cursor
    logic [CUR_W-1:0]   r_hi, n_hi;       // query: right cursor (exclusive)
    logic               r_side, n_side;   // which query cursor is being read
    t_node              r_acc, n_acc;     // update: current node value
    t_node              r_lacc, n_lacc;   // query: left accumulation
    t_node              r_racc, n_racc;   // query: right accumulation
    logic               r_strobe, n_strobe;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic               r_status, n_status;

    logic               mem_we;
    logic [NODE_W-1:0]  mem_waddr, mem_raddr;
    t_node              mem_wnode, rd_node;

    logic [SIZE_W-1:0]  eff_n;
    logic [SIZE_W-1:0]  qh_clip;

    assign eff_n   = (r_size > SIZE_W'(MAX_ENTRIES)) ? SIZE_W'(MAX_ENTRIES) : r_size;
    assign qh_clip = ({1'b0, i_range_high} > eff_n - 1'b1) ? eff_n - 1'b1
                                                           : {1'b0, i_range_high};
    assign rd_node = r_rdata;

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wnode;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_size   <= SIZE_W'(MAX_ENTRIES);
            r_strobe <= 1'b0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_clr    <= n_clr;
            if (i_cfg_we) r_size <= i_cfg_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_hi     <= n_hi;
        r_side   <= n_side;
        r_acc    <= n_acc;
        r_lacc   <= n_lacc;
        r_racc   <= n_racc;
        r_sum    <= n_sum;
        r_status <= n_status;
    end

    // Next state and memory control.
    always_comb begin
        logic signed [SUM_W-1:0] v48;
        t_node leaf, fin;
        n_state   = r_state;
        n_clr     = r_clr;
        n_node    = r_node;
        n_hi      = r_hi;
        n_side    = r_side;
        n_acc     = r_acc;
        n_lacc    = r_lacc;
        n_racc    = r_racc;
        n_strobe  = 1'b0;
        n_sum     = r_sum;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = NODE_W'(r_node);
        mem_wnode = r_acc;
        mem_raddr = NODE_W'(r_node) ^ NODE_W'(1);
        v48       = SUM_W'(i_new_value);
        leaf      = '{valid: 1'b1, pre: v48, suf: v48, tot: v48, best: v48};
        fin       = merge(r_lacc, r_racc);
        case (r_state)
            ST_CLEAR: begin
                // Empty every node, one entry a cycle.
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wnode = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == NODE_W'(MEM_D - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_SET) begin
                        if ({1'b0, i_position} < eff_n) begin
                            // Write leaf, read its sibling.
                            mem_we    = 1'b1;
                            mem_waddr = NODE_W'(MAX_ENTRIES) | NODE_W'(i_position);
                            mem_wnode = leaf;
                            mem_raddr = mem_waddr ^ NODE_W'(1);
                            n_node    = {1'b0, mem_waddr};
                            n_acc     = leaf;
                            n_state   = ST_UPD_MERGE;
                        end
                    end else begin
                        n_lacc.valid = 1'b0;
                        n_racc.valid = 1'b0;
                        if (eff_n == '0 || {1'b0, i_range_low} > qh_clip) begin
                            n_sum    = '0;
                            n_status = 1'b1;
                            n_strobe = 1'b1;
                        end else begin
                            n_node  = {1'b0, NODE_W'(MAX_ENTRIES) | NODE_W'(i_range_low)};
                            n_hi    = CUR_W'(CUR_W'(MAX_ENTRIES) + CUR_W'(qh_clip) + 1'b1);
                            n_state = ST_QRY_NEXT;
                        end
                    end
                end
            end
            ST_UPD_READ: begin
                mem_raddr = NODE_W'(r_node) ^ NODE_W'(1);
                n_state   = ST_UPD_MERGE;
            end
            ST_UPD_MERGE: begin
                // Merge with sibling, write parent.
                if (r_node[0]) n_acc = merge(rd_node, r_acc);
                else           n_acc = merge(r_acc, rd_node);
                mem_we    = 1'b1;
                mem_waddr = NODE_W'(r_node >> 1);
                mem_wnode = n_acc;
                n_node    = r_node >> 1;
                n_state   = ((r_node >> 1) == CUR_W'(1)) ? ST_IDLE : ST_UPD_READ;
            end
            ST_QRY_NEXT: begin
                // Bottom-up cursor walk; both cursors may reach 2*MAX_ENTRIES.
                if (r_node >= r_hi) begin
                    n_state = ST_QRY_DONE;
                end else if (r_node[0]) begin
                    mem_raddr = NODE_W'(r_node);
                    n_side    = 1'b0;
                    n_state   = ST_QRY_READ;
                end else if (r_hi[0]) begin
                    mem_raddr = NODE_W'(r_hi - 1'b1);
                    n_side    = 1'b1;
                    n_state   = ST_QRY_READ;
                end else begin
                    n_node = r_node >> 1;
                    n_hi   = r_hi >> 1;
                end
            end
            ST_QRY_READ: begin
                if (!r_side) begin
                    n_lacc = merge(r_lacc, rd_node);
                    n_node = r_node + 1'b1;
                end else begin
                    n_racc = merge(rd_node, r_racc);
                    n_hi   = r_hi - 1'b1;
                end
                n_state = ST_QRY_NEXT;
            end
            ST_QRY_DONE: begin
                n_strobe = 1'b1;
                n_status = !fin.valid;
                n_sum    = fin.valid ? fin.best : '0;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_strobe   = r_strobe;
    assign o_best_sum = r_sum;
    assign o_status   = r_status;
endmodule
`default_nettype wire

### hw/rtl/mss_checker.sv
// Checker on the top-level ports, bound to the top level.
`default_nettype none
module mss_port_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire logic o_status,
    input wire logic signed [47:0] o_best_sum
);
    // Empty result reports zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> o_best_sum == '0) else $error("empty result nonzero");
    // Result strobe only comes while idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("strobe while busy");
    // Strobed result is fully known.
    a_strobe_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown({o_best_sum, o_status})) else $error("unknown result");
    // Reset starts the clearing pass and drops the strobe.
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_strobe) else $error("not clearing after reset");
endmodule

bind max_subarray_segment_tree_top mss_port_checker u_mss_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_status(o_status), .o_best_sum(o_best_sum)
);
`default_nettype wire

### bench/mss_checker.sv
// Checker: predicts max-subarray query results and compares them with the block.
`timescale 1ns / 1ps
`default_nettype none
module mss_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic                              i_busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [mss_pkg::SIZE_W-1:0]        i_cfg_data,
    input  wire logic                              i_func,
    input  wire logic [mss_pkg::LEAF_W-1:0]        i_position,
    input  wire logic signed [mss_pkg::VAL_W-1:0]  i_new_value,
    input  wire logic [mss_pkg::LEAF_W-1:0]        i_range_low,
    input  wire logic [mss_pkg::LEAF_W-1:0]        i_range_high,
    input  wire logic                              i_strobe,
    input  wire logic signed [mss_pkg::SUM_W-1:0]  i_best_sum,
    input  wire logic                              i_status,
    output int                                     o_pending,
    output int                                     o_fail_count
);
    import mss_pkg::*;

    localparam int TREE_NODES = 4 * MAX_ENTRIES;

    typedef struct {
        longint pre;
        longint suf;
        longint tot;
        longint best;
        bit     valid;
    } t_sums;

    typedef struct {
        logic [SUM_W-1:0] best_sum;
        logic             status;
    } t_answer;

    t_sums           tree_nodes [TREE_NODES];
    int unsigned     entries_in_use;
    t_answer         answer_queue [$];

    // Empty side is the identity of the merge.
    function automatic t_sums join_sums(t_sums a, t_sums b);
        t_sums r;
        if (!a.valid) return b;
        if (!b.valid) return a;
        r.pre   = (a.pre > a.tot + b.pre) ? a.pre : a.tot + b.pre;
        r.suf   = (b.suf > b.tot + a.suf) ? b.suf : b.tot + a.suf;
        r.tot   = a.tot + b.tot;
        r.best  = (a.best > b.best) ? a.best : b.best;
        if (a.suf + b.pre > r.best) r.best = a.suf + b.pre;
        r.valid = 1'b1;
        return r;
    endfunction

    function automatic void load_entry(int k, int lo, int hi, int pos, longint v);
        int mid;
        if (lo == hi) begin
            tree_nodes[k] = '{v, v, v, v, 1'b1};
            return;
        end
        mid = lo + (hi - lo) / 2;
        if (pos <= mid) load_entry(2 * k + 1, lo, mid, pos, v);
        else load_entry(2 * k + 2, mid + 1, hi, pos, v);
        tree_nodes[k] = join_sums(tree_nodes[2 * k + 1], tree_nodes[2 * k + 2]);
    endfunction

    function automatic t_sums range_sums(int k, int lo, int hi, int ql, int qh);
        t_sums none;
        int mid;
        none = '{0, 0, 0, 0, 1'b0};
        if (k >= TREE_NODES || ql > hi || qh < lo) return none;
        if (lo >= ql && hi <= qh) return tree_nodes[k];
        mid = lo + (hi - lo) / 2;
        return join_sums(range_sums(2 * k + 1, lo, mid, ql, qh),
                         range_sums(2 * k + 2, mid + 1, hi, ql, qh));
    endfunction

    function automatic t_answer predict_query(int ql, int qh);
        t_answer a;
        t_sums s;
        a.best_sum = '0;
        a.status   = 1'b1;
        if (entries_in_use == 0) return a;
        if (qh > int'(entries_in_use) - 1) qh = entries_in_use - 1;
        if (ql > qh) return a;
        s = range_sums(0, 0, MAX_ENTRIES - 1, ql, qh);
        if (!s.valid) return a;
        a.best_sum = s.best[SUM_W-1:0];
        a.status   = 1'b0;
        return a;
    endfunction

    assign o_pending = answer_queue.size();

    initial begin
        o_fail_count   = 0;
        entries_in_use = MAX_ENTRIES;
        foreach (tree_nodes[i]) tree_nodes[i] = '{0, 0, 0, 0, 1'b0};
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (tree_nodes[i]) tree_nodes[i].valid = 1'b0;
            entries_in_use = MAX_ENTRIES;
            answer_queue.delete();
        end else begin
            // Compare a strobed result with the oldest expectation
            if (i_strobe) begin
                if (answer_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result best_sum=%0d status=%0d",
                                 i_best_sum, i_status);
                end else begin
                    want = answer_queue.pop_front();
                    if (want.best_sum !== i_best_sum || want.status !== i_status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: expected best_sum=%0d status=%0d, got %0d %0d",
                                     $signed(want.best_sum), want.status,
                                     i_best_sum, i_status);
                    end
                end
            end
            // Apply an accepted transaction with the size in force before this edge
            if (i_start && !i_busy) begin
                if (i_func == FUNC_SET) begin
                    if (i_position < entries_in_use)
                        load_entry(0, 0, MAX_ENTRIES - 1, i_position, longint'(i_new_value));
                end else begin
                    answer_queue.push_back(predict_query(i_range_low, i_range_high));
                end
            end
            // Track the size register
            if (i_cfg_we) begin
                entries_in_use = (i_cfg_data > MAX_ENTRIES) ? MAX_ENTRIES : i_cfg_data;
            end
        end
    end
endmodule
`default_nettype wire

### bench/testbench.sv
// Testbench top: drives updates, queries and size changes into the segment tree.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cfg_we;
    logic [SIZE_W-1:0]         i_cfg_data;
    logic                      i_func;
    logic [LEAF_W-1:0]         i_position;
    logic signed [VAL_W-1:0]   i_new_value;
    logic [LEAF_W-1:0]         i_range_low;
    logic [LEAF_W-1:0]         i_range_high;
    logic                      o_strobe;
    logic signed [SUM_W-1:0]   o_best_sum;
    logic                      o_status;
    int                        pending;
    int                        fail_count;
    int                        cycle_count;
    int                        idle_pct;
    int unsigned               cur_size;

    max_subarray_segment_tree_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_strobe     (o_strobe),
        .o_best_sum   (o_best_sum),
        .o_status     (o_status)
    );

    mss_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_strobe     (o_strobe),
        .i_best_sum   (o_best_sum),
        .i_status     (o_status),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one transaction at a falling edge and hold it until accepted
    task automatic issue(input logic func, input logic [LEAF_W-1:0] pos,
                         input logic [VAL_W-1:0] val, input logic [LEAF_W-1:0] lo,
                         input logic [LEAF_W-1:0] hi);
        i_func       = func;
        i_position   = pos;
        i_new_value  = val;
        i_range_low  = lo;
        i_range_high = hi;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Drain outstanding results, let an update finish, then write the size
    task automatic write_size(input logic [SIZE_W-1:0] size);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = size;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        cur_size   = (size > MAX_ENTRIES) ? MAX_ENTRIES : size;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 40) - 20;
            3: return $urandom;
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    function automatic logic [LEAF_W-1:0] pick_index();
        if (cur_size > 0 && $urandom_range(9) < 8)
            return LEAF_W'($urandom_range(cur_size - 1));
        return LEAF_W'($urandom);
    endfunction

    task automatic random_phase(input int count);
        logic [LEAF_W-1:0] a;
        logic [LEAF_W-1:0] b;
        for (int n = 0; n < count; n++) begin
            a = pick_index();
            b = pick_index();
            if ($urandom_range(9) < 5) begin
                issue(FUNC_SET, pick_index(), pick_value(), LEAF_W'($urandom),
                      LEAF_W'($urandom));
            end else if ($urandom_range(9) < 8) begin
                issue(FUNC_QUERY, LEAF_W'($urandom), $urandom, (a < b) ? a : b,
                      (a < b) ? b : a);
            end else begin
                issue(FUNC_QUERY, LEAF_W'($urandom), $urandom, a, b);
            end
        end
    endtask

    initial begin
        logic [SIZE_W-1:0] sizes [8];
        sizes = '{11'd1, 11'd2, 11'd2047, 11'd0, 11'd37, 11'd1024, 11'd100, 11'd5};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_func = FUNC_SET;
        i_position = '0;
        i_new_value = '0;
        i_range_low = '0;
        i_range_high = '0;
        idle_pct = 10;
        cur_size = MAX_ENTRIES;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tree, extremes, inverted and unloaded ranges
        issue(FUNC_QUERY, '0, '0, '0, LEAF_W'(1023));
        issue(FUNC_SET, '0, 32'h7FFF_FFFF, '0, '0);
        issue(FUNC_SET, LEAF_W'(1023), 32'h8000_0000, '0, '0);
        issue(FUNC_QUERY, '0, '0, '0, LEAF_W'(1023));
        issue(FUNC_QUERY, '0, '0, LEAF_W'(1023), LEAF_W'(1023));
        issue(FUNC_QUERY, '0, '0, LEAF_W'(500), LEAF_W'(600));
        issue(FUNC_QUERY, '0, '0, LEAF_W'(600), LEAF_W'(500));
        issue(FUNC_SET, LEAF_W'(1), 32'hFFFF_FFFF, '0, '0);
        issue(FUNC_SET, LEAF_W'(2), 32'h7FFF_FFFF, '0, '0);
        issue(FUNC_SET, LEAF_W'(512), 32'h0000_0000, '0, '0);
        issue(FUNC_QUERY, '0, '0, '0, LEAF_W'(2));
        issue(FUNC_QUERY, '0, '0, LEAF_W'(1), LEAF_W'(1));
        issue(FUNC_QUERY, '0, '0, LEAF_W'(1), LEAF_W'(1023));
        for (int k = 3; k < 10; k++) issue(FUNC_SET, LEAF_W'(k), 32'h7FFF_FFFF, '0, '0);
        issue(FUNC_QUERY, '0, '0, '0, LEAF_W'(1023));
        issue(FUNC_QUERY, '0, '0, LEAF_W'(1023), '0);
        random_phase(150);

        // Size sweep including zero, one and above the maximum
        for (int p = 0; p < 8; p++) begin
            if (p == 3) idle_pct = 59;
            if (p == 6) idle_pct = 0;
            write_size(sizes[p]);
            if (p == 2) begin
                issue(FUNC_QUERY, '0, '0, '0, LEAF_W'(1023));
                issue(FUNC_SET, LEAF_W'(1023), 32'h1234_5678, '0, '0);
            end
            random_phase((sizes[p] > 60) ? 260 : 150);
        end

        // Wait out the last results and any update still running
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/mss_pkg.sv
hw/rtl/max_subarray_segment_tree_top.sv
hw/rtl/mss_checker.sv
bench/mss_checker.sv
bench/testbench.sv
